// ===== rtl/ccimp_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle collision impulse package
// Fixed field widths, constants and status codes shared by the design.
// ----------------------------------------------------------------------------
package ccimp_pkg;

    localparam int INV_W       = 16;
    localparam int ISUM_W      = INV_W + 1;
    localparam int BOUNCE_W    = 9;
    localparam int BP_W        = BOUNCE_W + 1;
    localparam int BOUNCE_FRAC = 8;
    localparam int RADIUS_W    = 15;
    localparam int STATUS_W    = 2;

    localparam logic [BOUNCE_W-1:0] BOUNCE_ONE   = 9'd256;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd50;

    localparam logic [STATUS_W-1:0] ST_APART    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SEPARATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IMPULSE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DEGEN    = 2'd3;

endpackage

// ===== rtl/ccimp_wmul.sv =====
// ----------------------------------------------------------------------------
// Wide unsigned multiplier
// Two stages: four half-width partial products, then their registered sum.
// ----------------------------------------------------------------------------
module ccimp_wmul #(
    parameter int AW = 50,
    parameter int BW = 51
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] pp_ll_reg;
    logic [AL+BH-1:0] pp_lh_reg;
    logic [AH+BL-1:0] pp_hl_reg;
    logic [AH+BH-1:0] pp_hh_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
            pp_lh_reg <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
            pp_hl_reg <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
            pp_hh_reg <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
            p_reg     <= p_next;
        end
    end

    always_comb
    begin
        p_next = PW'(pp_ll_reg)
               + (PW'(pp_lh_reg) << BL)
               + (PW'(pp_hl_reg) << AL)
               + (PW'(pp_hh_reg) << (AL + BL));
    end

    assign p = p_reg;

endmodule

// ===== rtl/ccimp_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module ccimp_div #(
    parameter int NW = 101,
    parameter int DW = 76,
    parameter int QW = 26
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int SW = (NW > DW + QW) ? NW : DW + QW;

    logic [SW-1:0] rem_reg [0:QW-2];
    logic [DW-1:0] den_reg [0:QW-2];
    logic [QW-1:0] q_reg   [0:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int SH = QW - 1 - k;

        logic [SW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [SW-1:0] trial;
        logic [SW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign rem_in = SW'(num);
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            trial = SW'(den_in) << SH;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                q_next   = q_in | (QW'(1) << SH);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= q_next;
            end
        end

        if (k < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// ===== rtl/circle_collision_impulse_core.sv =====
// ----------------------------------------------------------------------------
// Circle collision impulse core
//
//   Channel   Signals                    Meaning
//   config    wr_en, wr_data             shared circle radius
//   input     in_valid, in_ready         one circle pair per beat
//   output    out_valid, out_ready       new velocities and status per beat
//
// One beat is accepted every cycle while the output is not stalled. The pipeline
// has three arithmetic stages, two wide multiply stages, one divider stage per
// quotient bit (COORD_WIDTH + 2) and the output register.
// Reset clears the valid bits and loads the radius of 50.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module circle_collision_impulse_core #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [ccimp_pkg::RADIUS_W-1:0]       wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        first_pos_x,
    input  logic signed [COORD_WIDTH-1:0]        first_pos_y,
    input  logic signed [COORD_WIDTH-1:0]        second_pos_x,
    input  logic signed [COORD_WIDTH-1:0]        second_pos_y,
    input  logic signed [COORD_WIDTH-1:0]        first_vel_x,
    input  logic signed [COORD_WIDTH-1:0]        first_vel_y,
    input  logic signed [COORD_WIDTH-1:0]        second_vel_x,
    input  logic signed [COORD_WIDTH-1:0]        second_vel_y,
    input  logic [ccimp_pkg::INV_W-1:0]          first_inv_mass,
    input  logic [ccimp_pkg::INV_W-1:0]          second_inv_mass,
    input  logic [ccimp_pkg::BOUNCE_W-1:0]       first_bounce,
    input  logic [ccimp_pkg::BOUNCE_W-1:0]       second_bounce,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ccimp_pkg::STATUS_W-1:0]       status,
    output logic signed [COORD_WIDTH-1:0]        new_first_vel_x,
    output logic signed [COORD_WIDTH-1:0]        new_first_vel_y,
    output logic signed [COORD_WIDTH-1:0]        new_second_vel_x,
    output logic signed [COORD_WIDTH-1:0]        new_second_vel_y
);

    import ccimp_pkg::*;

    localparam int C     = COORD_WIDTH;
    localparam int DXW   = C + 1;
    localparam int PRW   = 2 * DXW;
    localparam int NNW   = PRW + 1;
    localparam int VNW   = PRW + 2;
    localparam int MW    = PRW + 1;
    localparam int RSW   = RADIUS_W + FRAC_BITS + 1;
    localparam int RS2W  = 2 * RSW;
    localparam int CMPW  = (NNW > RS2W) ? NNW : RS2W;
    localparam int KW    = INV_W + BP_W;
    localparam int CWW   = KW + DXW;
    localparam int NUMW  = MW + CWW;
    localparam int D0W   = ISUM_W + NNW;
    localparam int DENW  = D0W + BOUNCE_FRAC;
    localparam int QW    = C + 2;
    localparam int SUMW  = C + 3;
    localparam int SBD   = QW + 2;
    localparam int NV    = SBD + 4;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic                sx;
        logic                sy;
        logic signed [C-1:0] v1x;
        logic signed [C-1:0] v1y;
        logic signed [C-1:0] v2x;
        logic signed [C-1:0] v2y;
    } side_t;

    function automatic logic signed [C-1:0] vel_update(
        input logic signed [C-1:0] v,
        input logic [QW-1:0]       q,
        input logic                neg
    );
        logic signed [SUMW-1:0] d;
        logic signed [SUMW-1:0] s;
        logic signed [C-1:0]    r;
        d = neg ? -$signed(SUMW'(q)) : $signed(SUMW'(q));
        s = SUMW'(v) + d;
        if ((s[SUMW-1:C-1] == '0) || (s[SUMW-1:C-1] == '1))
        begin
            r = s[C-1:0];
        end
        else if (s[SUMW-1])
        begin
            r = {1'b1, {(C-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(C-1){1'b1}}};
        end
        return r;
    endfunction

    logic                adv;
    logic [RADIUS_W-1:0] radius_reg;
    logic                vld_reg [0:NV-1];

    // Stage one: differences and magnitudes.
    logic signed [DXW-1:0] dx, dy, rvx, rvy;
    logic [BOUNCE_W-1:0]   emin, ecl;
    logic [DXW-1:0]        dxm_reg, dym_reg, rvxm_reg, rvym_reg;
    logic                  dxs_reg, dys_reg, rvxs_reg, rvys_reg;
    logic signed [C-1:0]   v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    logic [INV_W-1:0]      inv1_reg, inv2_reg;
    logic [ISUM_W-1:0]     isum_reg;
    logic [BP_W-1:0]       bp_reg;

    // Stage two: products.
    logic [PRW-1:0]        sqx_reg, sqy_reg, pvx_reg, pvy_reg;
    logic                  sgx_reg, sgy_reg;
    logic [KW-1:0]         k1_reg, k2_reg;
    logic [RS2W-1:0]       rs2_reg;
    logic [DXW-1:0]        dxm2_reg, dym2_reg;
    logic                  dxs2_reg, dys2_reg;
    logic signed [C-1:0]   v1x2_reg, v1y2_reg, v2x2_reg, v2y2_reg;
    logic [ISUM_W-1:0]     isum2_reg;
    logic [RSW-1:0]        rs;

    // Stage three: distance, approach speed and status.
    logic [NNW-1:0]        nn_next;
    logic signed [VNW-1:0] tx, ty, vn, vneg;
    logic [STATUS_W-1:0]   st_next;
    logic [NNW-1:0]        nn_reg;
    logic [MW-1:0]         m_reg;
    logic [CWW-1:0]        c11_reg, c12_reg, c21_reg, c22_reg;
    logic [ISUM_W-1:0]     isum3_reg;
    side_t                 side3_reg;
    side_t                 sb_reg [0:SBD-1];

    logic [NUMW-1:0]       num11, num12, num21, num22;
    logic [D0W-1:0]        den0;
    logic [DENW-1:0]       den;
    logic [QW-1:0]         q11, q12, q21, q22;
    side_t                 sb_last;

    logic [STATUS_W-1:0]   status_reg;
    logic signed [C-1:0]   n1x_reg, n1y_reg, n2x_reg, n2y_reg;

    assign adv      = !vld_reg[NV-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (wr_en)
        begin
            radius_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NV; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_comb
    begin
        dx   = DXW'(second_pos_x) - DXW'(first_pos_x);
        dy   = DXW'(second_pos_y) - DXW'(first_pos_y);
        rvx  = DXW'(second_vel_x) - DXW'(first_vel_x);
        rvy  = DXW'(second_vel_y) - DXW'(first_vel_y);
        emin = (first_bounce < second_bounce) ? first_bounce : second_bounce;
        ecl  = (emin > BOUNCE_ONE) ? BOUNCE_ONE : emin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxm_reg  <= dx[DXW-1] ? -dx : dx;
            dym_reg  <= dy[DXW-1] ? -dy : dy;
            rvxm_reg <= rvx[DXW-1] ? -rvx : rvx;
            rvym_reg <= rvy[DXW-1] ? -rvy : rvy;
            dxs_reg  <= dx[DXW-1];
            dys_reg  <= dy[DXW-1];
            rvxs_reg <= rvx[DXW-1];
            rvys_reg <= rvy[DXW-1];
            v1x_reg  <= first_vel_x;
            v1y_reg  <= first_vel_y;
            v2x_reg  <= second_vel_x;
            v2y_reg  <= second_vel_y;
            inv1_reg <= first_inv_mass;
            inv2_reg <= second_inv_mass;
            isum_reg <= ISUM_W'(first_inv_mass) + ISUM_W'(second_inv_mass);
            bp_reg   <= BP_W'(BOUNCE_ONE) + BP_W'(ecl);
        end
    end

    assign rs = RSW'(radius_reg) << (FRAC_BITS + 1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg   <= PRW'(dxm_reg) * PRW'(dxm_reg);
            sqy_reg   <= PRW'(dym_reg) * PRW'(dym_reg);
            pvx_reg   <= PRW'(rvxm_reg) * PRW'(dxm_reg);
            pvy_reg   <= PRW'(rvym_reg) * PRW'(dym_reg);
            sgx_reg   <= rvxs_reg ^ dxs_reg;
            sgy_reg   <= rvys_reg ^ dys_reg;
            k1_reg    <= KW'(inv1_reg) * KW'(bp_reg);
            k2_reg    <= KW'(inv2_reg) * KW'(bp_reg);
            rs2_reg   <= RS2W'(rs) * RS2W'(rs);
            dxm2_reg  <= dxm_reg;
            dym2_reg  <= dym_reg;
            dxs2_reg  <= dxs_reg;
            dys2_reg  <= dys_reg;
            v1x2_reg  <= v1x_reg;
            v1y2_reg  <= v1y_reg;
            v2x2_reg  <= v2x_reg;
            v2y2_reg  <= v2y_reg;
            isum2_reg <= isum_reg;
        end
    end

    always_comb
    begin
        nn_next = NNW'(sqx_reg) + NNW'(sqy_reg);
        tx      = sgx_reg ? -$signed(VNW'(pvx_reg)) : $signed(VNW'(pvx_reg));
        ty      = sgy_reg ? -$signed(VNW'(pvy_reg)) : $signed(VNW'(pvy_reg));
        vn      = tx + ty;
        vneg    = -vn;
        if (CMPW'(nn_next) >= CMPW'(rs2_reg))
        begin
            st_next = ST_APART;
        end
        else if (nn_next == '0)
        begin
            st_next = ST_DEGEN;
        end
        else if (vn > 0)
        begin
            st_next = ST_SEPARATE;
        end
        else if (isum2_reg == '0)
        begin
            st_next = ST_DEGEN;
        end
        else
        begin
            st_next = ST_IMPULSE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nn_reg        <= nn_next;
            m_reg         <= vneg[MW-1:0];
            c11_reg       <= CWW'(k1_reg) * CWW'(dxm2_reg);
            c12_reg       <= CWW'(k1_reg) * CWW'(dym2_reg);
            c21_reg       <= CWW'(k2_reg) * CWW'(dxm2_reg);
            c22_reg       <= CWW'(k2_reg) * CWW'(dym2_reg);
            isum3_reg     <= isum2_reg;
            side3_reg.st  <= st_next;
            side3_reg.sx  <= dxs2_reg;
            side3_reg.sy  <= dys2_reg;
            side3_reg.v1x <= v1x2_reg;
            side3_reg.v1y <= v1y2_reg;
            side3_reg.v2x <= v2x2_reg;
            side3_reg.v2y <= v2y2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= side3_reg;
            for (int i = 1; i < SBD; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    ccimp_wmul #(.AW(MW), .BW(CWW)) u_mul11 (
        .clk(clk), .en(adv), .a(m_reg), .b(c11_reg), .p(num11)
    );
    ccimp_wmul #(.AW(MW), .BW(CWW)) u_mul12 (
        .clk(clk), .en(adv), .a(m_reg), .b(c12_reg), .p(num12)
    );
    ccimp_wmul #(.AW(MW), .BW(CWW)) u_mul21 (
        .clk(clk), .en(adv), .a(m_reg), .b(c21_reg), .p(num21)
    );
    ccimp_wmul #(.AW(MW), .BW(CWW)) u_mul22 (
        .clk(clk), .en(adv), .a(m_reg), .b(c22_reg), .p(num22)
    );
    ccimp_wmul #(.AW(ISUM_W), .BW(NNW)) u_mulden (
        .clk(clk), .en(adv), .a(isum3_reg), .b(nn_reg), .p(den0)
    );

    assign den = DENW'(den0) << BOUNCE_FRAC;

    ccimp_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div11 (
        .clk(clk), .en(adv), .num(num11), .den(den), .quo(q11)
    );
    ccimp_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div12 (
        .clk(clk), .en(adv), .num(num12), .den(den), .quo(q12)
    );
    ccimp_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div21 (
        .clk(clk), .en(adv), .num(num21), .den(den), .quo(q21)
    );
    ccimp_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div22 (
        .clk(clk), .en(adv), .num(num22), .den(den), .quo(q22)
    );

    assign sb_last = sb_reg[SBD-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= sb_last.st;
            if (sb_last.st == ST_IMPULSE)
            begin
                n1x_reg <= vel_update(sb_last.v1x, q11, !sb_last.sx);
                n1y_reg <= vel_update(sb_last.v1y, q12, !sb_last.sy);
                n2x_reg <= vel_update(sb_last.v2x, q21, sb_last.sx);
                n2y_reg <= vel_update(sb_last.v2y, q22, sb_last.sy);
            end
            else
            begin
                n1x_reg <= sb_last.v1x;
                n1y_reg <= sb_last.v1y;
                n2x_reg <= sb_last.v2x;
                n2y_reg <= sb_last.v2y;
            end
        end
    end

    assign out_valid        = vld_reg[NV-1];
    assign status           = status_reg;
    assign new_first_vel_x  = n1x_reg;
    assign new_first_vel_y  = n1y_reg;
    assign new_second_vel_x = n2x_reg;
    assign new_second_vel_y = n2y_reg;

endmodule
